[design/assert_macros.svh]
// assertion macros used by plc_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define PLC_ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("plc check failed");

// next-cycle implication, disabled while reset is held
`define PLC_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("plc check failed");

// next-cycle implication, checked through reset as well
`define PLC_ASSERT_NEXT_ALWAYS(lbl, clk, a, c) \
    lbl: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("plc check failed");

`endif

[design/plc_pkg.sv]
// calibration table, slope constants and pipeline types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package plc_pkg;

    localparam int NUM_POINTS = 10;
    localparam int NUM_SEGS   = NUM_POINTS - 1;
    localparam int SEG_W      = $clog2(NUM_POINTS);
    localparam int RAW_W      = 12;
    localparam int TEMP_W     = 14;
    localparam int SLOPE_W    = 14;
    localparam int SLOPE_FRAC = 12;
    localparam int DIFF_W     = RAW_W + 1;
    localparam int PROD_W     = SLOPE_W + 1 + DIFF_W;
    localparam int CORR_W     = PROD_W - SLOPE_FRAC;
    localparam int IN_BYTES_W  = 16;
    localparam int OUT_BYTES_W = 16;

    localparam logic [RAW_W-1:0] PT_RAW [NUM_POINTS] = '{
        12'd140, 12'd200, 12'd300, 12'd400, 12'd500,
        12'd600, 12'd700, 12'd800, 12'd900, 12'd960
    };

    localparam logic signed [TEMP_W-1:0] PT_TRUE [NUM_POINTS] = '{
        14'sd232,  14'sd392,  14'sd600,  14'sd820,  14'sd1000,
        14'sd1200, 14'sd1360, 14'sd1492, 14'sd1620, 14'sd1672
    };

    localparam logic [SLOPE_W-1:0] SEG_SLOPE [NUM_SEGS] = '{
        14'd10923, 14'd8520, 14'd9011, 14'd7373, 14'd8192,
        14'd6554,  14'd5407, 14'd5243, 14'd3550
    };

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (SLOPE_FRAC - 1);

    typedef struct packed {
        logic [RAW_W-1:0] raw;
        logic [SEG_W-1:0] seg;
    } t_sel;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic [SEG_W-1:0]         seg;
    } t_mul;

endpackage

`default_nettype wire

[design/piecewise_linear_calibration_unit.sv]
// top level of the thermocouple calibration pipeline
// depends on plc_pkg, plc_seg_select, plc_slope_mul and plc_round_add
//
// usage:
// s_axis carries one raw reading per transfer (12 bits, quarter degrees, unsigned).
// m_axis returns one calibrated temperature per reading, in order
// (14 bits, two's complement, quarter degrees).
// each result reaches m_axis through the three register stages in order:
// segment select, slope multiply, round and add.
// throughput is one reading per cycle while the receiver keeps m_axis_tready high;
// each stage holds one item and takes the next as soon as its own item moves on.
// when the receiver stalls, the stages fill up and s_axis_tready drops after
// three held items; nothing is lost or repeated and the pending result holds.
// a synchronous active-low reset empties all stages; the block keeps no other state.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_calibration_unit
    import plc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_BYTES_W-1:0]  s_axis_tdata,  // [11:0] raw_reading, rest zero
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_BYTES_W-1:0]      m_axis_tdata   // [13:0] true_temperature, rest zero
);

    logic                     sel_valid;
    logic                     sel_ready;
    t_sel                     sel;
    logic                     mul_valid;
    logic                     mul_ready;
    t_mul                     mul;
    logic signed [TEMP_W-1:0] temp;

    plc_seg_select u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_raw   (s_axis_tdata[RAW_W-1:0]),
        .o_valid (sel_valid),
        .i_ready (sel_ready),
        .o_sel   (sel)
    );

    plc_slope_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sel_valid),
        .o_ready (sel_ready),
        .i_sel   (sel),
        .o_valid (mul_valid),
        .i_ready (mul_ready),
        .o_mul   (mul)
    );

    plc_round_add u_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .o_ready (mul_ready),
        .i_mul   (mul),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_temp  (temp)
    );

    assign m_axis_tdata = {{(OUT_BYTES_W - TEMP_W){1'b0}}, temp};

endmodule

`default_nettype wire

[design/plc_seg_select.sv]
// stage one: compares the reading with the inner table points and registers the segment
// depends on plc_pkg
`timescale 1ns / 1ps
`default_nettype none

module plc_seg_select
    import plc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [RAW_W-1:0] i_raw,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_sel                  o_sel
);

    logic             r_valid;
    t_sel             r_sel;
    logic [SEG_W-1:0] n_seg;

    // segment index is the number of inner points lying strictly below the reading
    always_comb begin
        n_seg = '0;
        for (int k = 1; k < NUM_POINTS - 1; k++) begin
            if (i_raw > PT_RAW[k]) begin
                n_seg = n_seg + SEG_W'(1);
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sel.raw <= i_raw;
            r_sel.seg <= n_seg;
        end
    end

    assign o_valid = r_valid;
    assign o_sel   = r_sel;

endmodule

`default_nettype wire

[design/plc_slope_mul.sv]
// stage two: distance from the segment's lower point times the segment slope
// depends on plc_pkg
`timescale 1ns / 1ps
`default_nettype none

module plc_slope_mul
    import plc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_sel i_sel,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_mul      o_mul
);

    logic                      r_valid;
    t_mul                      r_mul;
    logic signed [DIFF_W-1:0]  n_diff;
    logic signed [SLOPE_W:0]   n_slope;
    logic signed [PROD_W-1:0]  n_prod;

    always_comb begin
        n_diff  = $signed({1'b0, i_sel.raw}) - $signed({1'b0, PT_RAW[i_sel.seg]});
        n_slope = $signed({1'b0, SEG_SLOPE[i_sel.seg]});
        n_prod  = PROD_W'(n_slope) * PROD_W'(n_diff);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mul.prod <= n_prod;
            r_mul.seg  <= i_sel.seg;
        end
    end

    assign o_valid = r_valid;
    assign o_mul   = r_mul;

endmodule

`default_nettype wire

[design/plc_round_add.sv]
// stage three: rounds the product to whole steps and adds the lower point's true value
// depends on plc_pkg
`timescale 1ns / 1ps
`default_nettype none

module plc_round_add
    import plc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire t_mul                i_mul,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic signed [TEMP_W-1:0] o_temp
);

    logic                      r_valid;
    logic signed [TEMP_W-1:0]  r_temp;
    logic signed [PROD_W-1:0]  n_biased;
    logic signed [CORR_W-1:0]  n_corr;
    logic signed [CORR_W-1:0]  n_sum;

    // arithmetic shift gives floor, so halves round toward plus infinity
    always_comb begin
        n_biased = i_mul.prod + $signed(ROUND_HALF);
        n_corr   = CORR_W'(n_biased >>> SLOPE_FRAC);
        n_sum    = CORR_W'(PT_TRUE[i_mul.seg]) + n_corr;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_temp <= n_sum[TEMP_W-1:0];
        end
    end

    assign o_valid = r_valid;
    assign o_temp  = r_temp;

endmodule

`default_nettype wire

[design/plc_checker.sv]
// port-level checks for the calibration pipeline, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module plc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    `PLC_ASSERT_NEXT_ALWAYS(a_reset_empties, i_clk, !i_rst_n, !m_axis_tvalid)
    `PLC_ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
    `PLC_ASSERT_IMPLY(a_ready_when_drained, i_clk, i_rst_n, m_axis_tready, s_axis_tready)
    `PLC_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind piecewise_linear_calibration_unit plc_checker u_plc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[tb/piecewise_linear_calibration_unit_tb.sv]
// self-checking testbench for the piecewise linear thermocouple calibration unit
// drives raw readings over s_axis; checks m_axis against typed rows or a local predictor
// depends on plc_pkg and piecewise_linear_calibration_unit
`timescale 1ns / 1ps

module piecewise_linear_calibration_unit_tb;

    import plc_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_HOLD     = 80;
    localparam int FILL_ITEMS    = 48;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int STEADY_ITEMS  = 230;
    localparam int MAX_PRINTED   = 40;
    localparam int ROUND_Q12     = 1 << (SLOPE_FRAC - 1);
    localparam int RAW_MAX       = (1 << RAW_W) - 1;

    localparam int N_KNOTS = 10;
    localparam int KNOT_RAW  [N_KNOTS] = '{140, 200, 300, 400, 500, 600, 700, 800, 900, 960};
    localparam int KNOT_TEMP [N_KNOTS] = '{232, 392, 600, 820, 1000, 1200, 1360, 1492, 1620,
                                           1672};
    localparam int SLOPE_Q12 [N_KNOTS-1] = '{10923, 8520, 9011, 7373, 8192, 6554, 5407, 5243,
                                             3550};

    typedef enum logic [1:0] {
        PH_DIRECTED,
        PH_FILL,
        PH_RANDOM,
        PH_STEADY
    } t_phase;

    typedef struct packed {
        logic [RAW_W-1:0]         raw;
        logic                     is_typed;
        logic signed [TEMP_W-1:0] temp;
    } t_row;

    localparam int N_ROWS = 24;
    localparam t_row ROWS [N_ROWS] = '{
        '{12'd0,    1'b1, -14'sd141},
        '{12'd4095, 1'b1, 14'sd4389},
        '{12'd140,  1'b1, 14'sd232},
        '{12'd960,  1'b1, 14'sd1672},
        '{12'd200,  1'b1, 14'sd392},
        '{12'd1,    1'b0, 14'sd0},
        '{12'd139,  1'b0, 14'sd0},
        '{12'd141,  1'b0, 14'sd0},
        '{12'd199,  1'b0, 14'sd0},
        '{12'd201,  1'b0, 14'sd0},
        '{12'd300,  1'b0, 14'sd0},
        '{12'd400,  1'b0, 14'sd0},
        '{12'd500,  1'b0, 14'sd0},
        '{12'd600,  1'b0, 14'sd0},
        '{12'd700,  1'b0, 14'sd0},
        '{12'd800,  1'b0, 14'sd0},
        '{12'd900,  1'b0, 14'sd0},
        '{12'd899,  1'b0, 14'sd0},
        '{12'd901,  1'b0, 14'sd0},
        '{12'd959,  1'b0, 14'sd0},
        '{12'd961,  1'b0, 14'sd0},
        '{12'd1365, 1'b0, 14'sd0},
        '{12'd2730, 1'b0, 14'sd0},
        '{12'd2048, 1'b0, 14'sd0}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_BYTES_W-1:0]   s_axis_tdata;   // [11:0] raw_reading, rest zero
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_BYTES_W-1:0]  m_axis_tdata;   // [13:0] true_temperature, rest zero

    logic                     drv_typed;
    logic signed [TEMP_W-1:0] drv_temp;
    logic signed [TEMP_W-1:0] temps_due [$];
    t_phase                   run_phase = PH_DIRECTED;
    bit                       long_hold_done = 1'b0;
    int                       errors = 0;

    piecewise_linear_calibration_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // segment ending on an inner knot wins; outer segments are extended
    function automatic logic signed [TEMP_W-1:0] calibrate_reading(input logic [RAW_W-1:0] raw);
        int x;
        int k;
        int prod;
        x = int'(raw);
        k = 0;
        if (x >= KNOT_RAW[N_KNOTS-1]) begin
            k = N_KNOTS - 2;
        end else if (x > KNOT_RAW[0]) begin
            while (x > KNOT_RAW[k+1]) k++;
        end
        prod = SLOPE_Q12[k] * (x - KNOT_RAW[k]);
        return TEMP_W'(KNOT_TEMP[k] + ((prod + ROUND_Q12) >>> SLOPE_FRAC));
    endfunction

    function automatic logic [RAW_W-1:0] random_reading();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                v = $urandom_range(0, RAW_MAX);
            end
            3: begin
                v = KNOT_RAW[$urandom_range(0, N_KNOTS-1)] + int'($urandom_range(0, 4)) - 2;
            end
            default: begin
                v = $urandom_range(KNOT_RAW[0], KNOT_RAW[N_KNOTS-1]);
            end
        endcase
        return RAW_W'(v);
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("error at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic offer_reading(input logic [RAW_W-1:0] raw, input logic is_typed,
                                 input logic signed [TEMP_W-1:0] temp);
        if ((run_phase == PH_DIRECTED || run_phase == PH_RANDOM) && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_BYTES_W'(raw);
        drv_typed     <= is_typed;
        drv_temp      <= temp;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // sender: reset, directed rows, back-pressure fill, random, then steady stream
    initial begin
        int n;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        drv_typed     <= 1'b0;
        drv_temp      <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_ROWS; i++) begin
            offer_reading(ROWS[i].raw, ROWS[i].is_typed, ROWS[i].temp);
        end

        run_phase = PH_FILL;
        n = 0;
        while (!long_hold_done || n < FILL_ITEMS) begin
            offer_reading(random_reading(), 1'b0, '0);
            n++;
        end

        run_phase = PH_RANDOM;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            offer_reading(random_reading(), 1'b0, '0);
        end

        run_phase = PH_STEADY;
        for (int i = 0; i < STEADY_ITEMS; i++) begin
            offer_reading(random_reading(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (temps_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (temps_due.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", temps_due.size()));
        end

        if (errors == 0) begin
            $display("piecewise_linear_calibration_unit: match");
        end else begin
            $display("piecewise_linear_calibration_unit: mismatch");
        end
        $finish;
    end

    // receiver: random stalls, one long hold while the fill runs
    initial begin
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (run_phase == PH_STEADY) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else if (run_phase == PH_FILL && !long_hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_done = 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
                if ($urandom_range(0, 1) == 1) begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(1, 18)) @(posedge i_clk);
                end
            end
        end
    end

    // results are compared before the same edge's input transfer is queued
    always @(posedge i_clk) begin : scoreboard
        logic signed [TEMP_W-1:0] want;
        if (i_rst_n === 1'b1) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (temps_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d with nothing pending",
                                              $signed(m_axis_tdata[TEMP_W-1:0])));
                end else begin
                    want = temps_due.pop_front();
                    if (m_axis_tdata[TEMP_W-1:0] !== want) begin
                        report_mismatch($sformatf("true_temperature %0d, expected %0d",
                                                  $signed(m_axis_tdata[TEMP_W-1:0]), want));
                    end
                    if (m_axis_tdata[OUT_BYTES_W-1:TEMP_W] !== '0) begin
                        report_mismatch($sformatf("padding bits 'h%0h, expected zero",
                                                  m_axis_tdata[OUT_BYTES_W-1:TEMP_W]));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                temps_due.push_back(drv_typed ? drv_temp
                                              : calibrate_reading(s_axis_tdata[RAW_W-1:0]));
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("piecewise_linear_calibration_unit: mismatch");
        $finish;
    end

endmodule
